// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cht assertion failed");

// next-cycle implication, disabled during reset
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cht assertion failed");

`endif

// ----- rtl/cht_pkg.sv -----
// shared types and codes of the chained hash table engine
// no dependencies
`timescale 1ns / 1ps

package cht_pkg;

    // request codes
    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_ERASE   = 3'd1;
    localparam logic [2:0] REQ_FIND    = 3'd2;
    localparam logic [2:0] REQ_EMPLACE = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // bucket count after reset
    localparam logic [6:0] CFG_RESET = 7'd16;

    // datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_LOAD      = 4'd1;
    localparam logic [3:0] CMD_DIV       = 4'd2;
    localparam logic [3:0] CMD_HEAD_RD   = 4'd3;
    localparam logic [3:0] CMD_WALK_INIT = 4'd4;
    localparam logic [3:0] CMD_NODE_RD   = 4'd5;
    localparam logic [3:0] CMD_ADVANCE   = 4'd6;
    localparam logic [3:0] CMD_FREE_RD   = 4'd7;
    localparam logic [3:0] CMD_PUSH      = 4'd8;
    localparam logic [3:0] CMD_UNLINK    = 4'd9;
    localparam logic [3:0] CMD_RELEASE   = 4'd10;
    localparam logic [3:0] CMD_HIT       = 4'd11;
    localparam logic [3:0] CMD_MISS      = 4'd12;
    localparam logic [3:0] CMD_FULL      = 4'd13;
    localparam logic [3:0] CMD_CLEAR     = 4'd14;
    localparam logic [3:0] CMD_EMIT      = 4'd15;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] key_hash;
        logic [63:0] key_word;
        logic [31:0] value_word;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic        created;
        logic [8:0]  element_count;
    } rsp_t;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       div_last;
        logic       cur_nil;
        logic       match;
        logic       free_nil;
        logic       out_free;
    } stat_t;

endpackage

// ----- rtl/cht_ctrl.sv -----
// controller state machine of the chained hash table engine
// depends on cht_pkg
`timescale 1ns / 1ps

module cht_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cht_pkg::stat_t stat,
    output cht_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_FREE  = 4'd4;
    localparam logic [3:0] S_PUSH  = 4'd5;
    localparam logic [3:0] S_WINIT = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_REL   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // one request at a time
    assign req_stall = (state_reg != S_IDLE);

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = cht_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = cht_pkg::CMD_LOAD;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = cht_pkg::CMD_DIV;
                if (stat.div_last)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                case (stat.req_type)
                    cht_pkg::REQ_CLEAR:
                    begin
                        cmd.op     = cht_pkg::CMD_CLEAR;
                        state_next = S_EMIT;
                    end
                    cht_pkg::REQ_INSERT:
                    begin
                        cmd.op     = cht_pkg::CMD_HEAD_RD;
                        state_next = S_INS;
                    end
                    cht_pkg::REQ_ERASE, cht_pkg::REQ_FIND, cht_pkg::REQ_EMPLACE:
                    begin
                        cmd.op     = cht_pkg::CMD_HEAD_RD;
                        state_next = S_WINIT;
                    end
                    default:
                    begin
                        cmd.op     = cht_pkg::CMD_MISS;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_INS:
            begin
                cmd.op     = cht_pkg::CMD_WALK_INIT;
                state_next = S_FREE;
            end
            S_FREE:
            begin
                if (stat.free_nil)
                begin
                    cmd.op     = cht_pkg::CMD_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.op     = cht_pkg::CMD_FREE_RD;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.op     = cht_pkg::CMD_PUSH;
                state_next = S_EMIT;
            end
            S_WINIT:
            begin
                cmd.op     = cht_pkg::CMD_WALK_INIT;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!stat.cur_nil)
                begin
                    cmd.op     = cht_pkg::CMD_NODE_RD;
                    state_next = S_CMP;
                end
                else if (stat.req_type == cht_pkg::REQ_EMPLACE)
                begin
                    state_next = S_FREE;
                end
                else
                begin
                    cmd.op     = cht_pkg::CMD_MISS;
                    state_next = S_EMIT;
                end
            end
            S_CMP:
            begin
                if (!stat.match)
                begin
                    cmd.op     = cht_pkg::CMD_ADVANCE;
                    state_next = S_CHK;
                end
                else if (stat.req_type == cht_pkg::REQ_ERASE)
                begin
                    cmd.op     = cht_pkg::CMD_UNLINK;
                    state_next = S_REL;
                end
                else
                begin
                    cmd.op     = cht_pkg::CMD_HIT;
                    state_next = S_EMIT;
                end
            end
            S_REL:
            begin
                cmd.op     = cht_pkg::CMD_RELEASE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = cht_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/cht_datapath.sv -----
// datapath of the chained hash table engine: bucket remainder, memories, walk registers
// depends on cht_pkg
`timescale 1ns / 1ps

module cht_datapath
#(
    parameter int MAX_BUCKETS = 64,
    parameter int POOL_NODES  = 256,
    parameter int KEY_BITS    = 64,
    parameter int VALUE_BITS  = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [6:0]     cfg_wdata,
    input  cht_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cht_pkg::rsp_t  rsp,
    input  cht_pkg::cmd_t  cmd,
    output cht_pkg::stat_t stat
);

    localparam int AW = $clog2(POOL_NODES);
    localparam int NW = $clog2(POOL_NODES + 1);
    localparam int BW = $clog2(MAX_BUCKETS + 1);
    localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

    // request and walk registers
    logic [6:0]          cfg_reg;
    logic [2:0]          type_reg;
    logic [31:0]         hash_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VW-1:0]       val_reg;
    logic [31:0]         sh_reg;
    logic [BW-1:0]       rem_reg;
    logic [2:0]          div_cnt_reg;
    logic [NW-1:0]       cur_reg;
    logic [NW-1:0]       prev_reg;
    logic [NW-1:0]       steps_reg;
    logic [NW-1:0]       head_reg;
    logic [NW-1:0]       free_head_reg;
    logic [NW-1:0]       count_reg;
    logic [1:0]          res_status_reg;
    logic [VW-1:0]       res_value_reg;
    logic                res_created_reg;
    logic                out_valid_reg;
    cht_pkg::rsp_t       out_reg;

    // memories and read data
    logic [NW-1:0]       head_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] head_vld;
    logic [NW-1:0]       head_raw;
    logic                head_vld_rd;
    logic [NW-1:0]       link_mem [POOL_NODES];
    logic [POOL_NODES-1:0] link_vld;
    logic [NW-1:0]       link_raw;
    logic                link_vld_rd;
    logic [AW-1:0]       link_addr_rd;
    logic [31:0]         hash_mem [POOL_NODES];
    logic [KEY_BITS-1:0] key_mem [POOL_NODES];
    logic [VW-1:0]       val_mem [POOL_NODES];
    logic [31:0]         nh_q;
    logic [KEY_BITS-1:0] nk_q;
    logic [VW-1:0]       nv_q;

    logic [BW-1:0]       n_eff;
    logic [BW-1:0]       rem_step;
    logic [IW-1:0]       bkt;
    logic [NW-1:0]       head_q;
    logic [NW-1:0]       nl_q;
    logic                prev_nil;
    logic                link_rd;
    logic [AW-1:0]       link_rd_addr;
    logic                link_we;
    logic [AW-1:0]       link_wr_addr;
    logic [NW-1:0]       link_wr_data;

    // effective bucket count, clamped to 1..MAX_BUCKETS
    always_comb
    begin
        if (cfg_reg == 7'd0)
            n_eff = BW'(1);
        else if (32'(cfg_reg) > MAX_BUCKETS)
            n_eff = BW'(MAX_BUCKETS);
        else
            n_eff = BW'(cfg_reg);
    end

    // four restoring remainder steps per cycle
    always_comb
    begin
        logic [BW:0]   t;
        logic [BW-1:0] r;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < 4; i++)
        begin
            t = {r, sh_reg[31-i]};
            if (t >= {1'b0, n_eff})
                t = t - {1'b0, n_eff};
            r = t[BW-1:0];
        end
        rem_step = r;
    end

    assign bkt      = rem_reg[IW-1:0];
    assign head_q   = head_vld_rd ? head_raw : NIL;
    assign nl_q     = link_vld_rd ? link_raw : (NW'(link_addr_rd) + NW'(1));
    assign prev_nil = (prev_reg >= NIL);

    // status to the controller
    assign stat.req_type = type_reg;
    assign stat.div_last = (div_cnt_reg == 3'd7);
    assign stat.cur_nil  = (cur_reg >= NIL) || (steps_reg >= NIL);
    assign stat.match    = (nh_q == hash_reg) && (nk_q == key_reg);
    assign stat.free_nil = (free_head_reg >= NIL);
    assign stat.out_free = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= cht_pkg::CFG_RESET;
            div_cnt_reg   <= '0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            steps_reg     <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (cmd.op == cht_pkg::CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                cht_pkg::CMD_LOAD:
                    div_cnt_reg <= '0;
                cht_pkg::CMD_DIV:
                    div_cnt_reg <= div_cnt_reg + 3'd1;
                cht_pkg::CMD_WALK_INIT:
                begin
                    cur_reg   <= head_q;
                    prev_reg  <= NIL;
                    steps_reg <= '0;
                end
                cht_pkg::CMD_ADVANCE:
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= nl_q;
                    steps_reg <= steps_reg + NW'(1);
                end
                cht_pkg::CMD_PUSH:
                begin
                    free_head_reg <= nl_q;
                    count_reg     <= count_reg + NW'(1);
                end
                cht_pkg::CMD_RELEASE:
                begin
                    free_head_reg <= cur_reg;
                    if (count_reg != '0)
                        count_reg <= count_reg - NW'(1);
                end
                cht_pkg::CMD_CLEAR:
                begin
                    free_head_reg <= '0;
                    count_reg     <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cht_pkg::CMD_LOAD:
            begin
                type_reg <= req.req_type;
                hash_reg <= req.key_hash;
                key_reg  <= req.key_word[KEY_BITS-1:0];
                val_reg  <= req.value_word[VW-1:0];
                sh_reg   <= req.key_hash;
                rem_reg  <= '0;
            end
            cht_pkg::CMD_DIV:
            begin
                sh_reg  <= {sh_reg[27:0], 4'd0};
                rem_reg <= rem_step;
            end
            cht_pkg::CMD_WALK_INIT:
                head_reg <= head_q;
            cht_pkg::CMD_PUSH:
            begin
                res_status_reg  <= cht_pkg::ST_OK;
                res_value_reg   <= '0;
                res_created_reg <= (type_reg == cht_pkg::REQ_EMPLACE);
            end
            cht_pkg::CMD_RELEASE, cht_pkg::CMD_HIT:
            begin
                res_status_reg  <= cht_pkg::ST_OK;
                res_value_reg   <= nv_q;
                res_created_reg <= 1'b0;
            end
            cht_pkg::CMD_MISS:
            begin
                res_status_reg  <= cht_pkg::ST_NOTFOUND;
                res_value_reg   <= '0;
                res_created_reg <= 1'b0;
            end
            cht_pkg::CMD_FULL:
            begin
                res_status_reg  <= cht_pkg::ST_FULL;
                res_value_reg   <= '0;
                res_created_reg <= 1'b0;
            end
            cht_pkg::CMD_CLEAR:
            begin
                res_status_reg  <= cht_pkg::ST_OK;
                res_value_reg   <= '0;
                res_created_reg <= 1'b0;
            end
            cht_pkg::CMD_EMIT:
            begin
                out_reg.status        <= res_status_reg;
                out_reg.value_out     <= 32'(res_value_reg);
                out_reg.created       <= res_created_reg;
                out_reg.element_count <= 9'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    // bucket head valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld    <= '0;
            head_vld_rd <= 1'b0;
        end
        else
        begin
            if (cmd.op == cht_pkg::CMD_HEAD_RD)
                head_vld_rd <= head_vld[bkt];
            if (cmd.op == cht_pkg::CMD_CLEAR)
                head_vld <= '0;
            else if (cmd.op == cht_pkg::CMD_PUSH ||
                     (cmd.op == cht_pkg::CMD_UNLINK && prev_nil))
                head_vld[bkt] <= 1'b1;
        end
    end

    // bucket head memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == cht_pkg::CMD_HEAD_RD)
            head_raw <= head_mem[bkt];
        if (cmd.op == cht_pkg::CMD_PUSH)
            head_mem[bkt] <= free_head_reg;
        else if (cmd.op == cht_pkg::CMD_UNLINK && prev_nil)
            head_mem[bkt] <= nl_q;
    end

    // link port selection
    always_comb
    begin
        link_rd      = (cmd.op == cht_pkg::CMD_NODE_RD) || (cmd.op == cht_pkg::CMD_FREE_RD);
        link_rd_addr = (cmd.op == cht_pkg::CMD_NODE_RD) ? cur_reg[AW-1:0]
                                                        : free_head_reg[AW-1:0];
        link_we      = 1'b0;
        link_wr_addr = free_head_reg[AW-1:0];
        link_wr_data = head_reg;
        case (cmd.op)
            cht_pkg::CMD_PUSH:
                link_we = 1'b1;
            cht_pkg::CMD_UNLINK:
            begin
                link_we      = !prev_nil;
                link_wr_addr = prev_reg[AW-1:0];
                link_wr_data = nl_q;
            end
            cht_pkg::CMD_RELEASE:
            begin
                link_we      = 1'b1;
                link_wr_addr = cur_reg[AW-1:0];
                link_wr_data = free_head_reg;
            end
            default:
            begin
            end
        endcase
    end

    // link valid bits, an unwritten link points at the next node
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld    <= '0;
            link_vld_rd <= 1'b0;
        end
        else
        begin
            if (link_rd)
                link_vld_rd <= link_vld[link_rd_addr];
            if (cmd.op == cht_pkg::CMD_CLEAR)
                link_vld <= '0;
            else if (link_we)
                link_vld[link_wr_addr] <= 1'b1;
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (link_rd)
        begin
            link_raw     <= link_mem[link_rd_addr];
            link_addr_rd <= link_rd_addr;
        end
        if (link_we)
            link_mem[link_wr_addr] <= link_wr_data;
    end

    // node hash, key and value memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == cht_pkg::CMD_NODE_RD)
        begin
            nh_q <= hash_mem[cur_reg[AW-1:0]];
            nk_q <= key_mem[cur_reg[AW-1:0]];
            nv_q <= val_mem[cur_reg[AW-1:0]];
        end
        if (cmd.op == cht_pkg::CMD_PUSH)
        begin
            hash_mem[free_head_reg[AW-1:0]] <= hash_reg;
            key_mem[free_head_reg[AW-1:0]]  <= key_reg;
            val_mem[free_head_reg[AW-1:0]]  <=
                (type_reg == cht_pkg::REQ_EMPLACE) ? '0 : val_reg;
        end
    end

endmodule

// ----- rtl/chained_hash_table_engine.sv -----
// Chained hash table engine: a hash table with separate chaining over a fixed node pool.
// The bucket remainder runs at 4 bits per cycle; a find, erase or emplace then walks the
// chain with one read and one compare per node over the single-port node memories, and
// an emplace that creates or an insert pops the free list and pushes a node; clear and
// unknown codes walk no chain. A stalled result beat holds the next request back.
// Clear resets the bucket heads and free list at once through per-entry valid bits.
// depends on cht_pkg, cht_ctrl, cht_datapath
`timescale 1ns / 1ps

module chained_hash_table_engine
#(
    parameter int MAX_BUCKETS = 64,
    parameter int POOL_NODES  = 256,
    parameter int KEY_BITS    = 64,
    parameter int VALUE_BITS  = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_wdata,
    input  logic          req_valid,
    output logic          req_stall,
    input  cht_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cht_pkg::rsp_t rsp
);

    cht_pkg::cmd_t  cmd;
    cht_pkg::stat_t stat;

    // sequencer
    cht_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and arithmetic
    cht_datapath
    #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- rtl/cht_checker.sv -----
// port-level checks of the chained hash table engine, bound to the top level
// depends on cht_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cht_checker
#(
    parameter int POOL_NODES = 256
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cht_pkg::rsp_t rsp
);

    // a stalled result beat stays
    `CHT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)

    // a created entry reports ok with a zero value
    `CHT_ASSERT_IMPL(a_created_ok, clk, rst_n, rsp_valid && rsp.created,
        rsp.status == cht_pkg::ST_OK && rsp.value_out == 32'd0)

    // a full table reports nothing else
    `CHT_ASSERT_IMPL(a_full_clean, clk, rst_n, rsp_valid && rsp.status == cht_pkg::ST_FULL,
        rsp.value_out == 32'd0 && !rsp.created)

    // never more entries than the pool holds
    `CHT_ASSERT_IMPL(a_count_max, clk, rst_n, rsp_valid,
        32'(rsp.element_count) <= POOL_NODES || POOL_NODES > 511)

    // an accepted request blocks the next one
    `CHT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && !req_stall, req_stall)

endmodule

bind chained_hash_table_engine cht_checker #(.POOL_NODES(POOL_NODES)) u_cht_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ----- dv/chained_hash_table_engine_test.sv -----
// self-checking testbench of the chained hash table engine: directed and random requests
// depends on cht_pkg and chained_hash_table_engine
`timescale 1ns / 1ps

module chained_hash_table_engine_test;

    localparam int NBUCK = 64;
    localparam int NPOOL = 256;
    localparam int NIL   = 256;

    // table model kept by the scoreboard
    class hash_table_scoreboard;
        int unsigned   bucket_cfg;
        int unsigned   head[NBUCK];
        logic [31:0]   nhash[NPOOL];
        logic [63:0]   nkey[NPOOL];
        logic [31:0]   nval[NPOOL];
        int unsigned   nlink[NPOOL];
        int unsigned   free_top;
        int unsigned   count;
        cht_pkg::rsp_t pending[$];
        int            errors;
        int            checked;

        function void wipe();
            for (int i = 0; i < NBUCK; i++) head[i] = NIL;
            for (int i = 0; i < NPOOL; i++) nlink[i] = i + 1;
            free_top = 0;
            count = 0;
        endfunction

        function void init();
            bucket_cfg = cht_pkg::CFG_RESET;
            for (int i = 0; i < NPOOL; i++)
            begin
                nhash[i] = '0;
                nkey[i] = '0;
                nval[i] = '0;
            end
            wipe();
            errors = 0;
            checked = 0;
        endfunction

        function int unsigned bucket_index(logic [31:0] h);
            int unsigned n;
            n = bucket_cfg;
            if (n == 0) n = 1;
            if (n > NBUCK) n = NBUCK;
            return h % n;
        endfunction

        // newest match in a chain, prev gives the node before it
        function int unsigned lookup(int unsigned b, logic [31:0] h, logic [63:0] k,
                                     output int unsigned prev);
            int unsigned cur;
            int unsigned pr;
            int steps;
            cur = head[b];
            pr = NIL;
            steps = 0;
            prev = NIL;
            while (cur < NPOOL && steps < NPOOL)
            begin
                if (nhash[cur] == h && nkey[cur] == k)
                begin
                    prev = pr;
                    return cur;
                end
                pr = cur;
                cur = nlink[cur];
                steps++;
            end
            return NIL;
        endfunction

        function bit push(int unsigned b, logic [31:0] h, logic [63:0] k, logic [31:0] v);
            int unsigned n;
            n = free_top;
            if (n >= NPOOL) return 0;
            free_top = nlink[n];
            nhash[n] = h;
            nkey[n] = k;
            nval[n] = v;
            nlink[n] = head[b];
            head[b] = n;
            count++;
            return 1;
        endfunction

        // note an accepted request beat and queue its expected response
        function void note_request(cht_pkg::req_t r);
            cht_pkg::rsp_t e;
            int unsigned b, hit, prev;
            b = bucket_index(r.key_hash);
            e = '0;
            e.status = cht_pkg::ST_NOTFOUND;
            case (r.req_type)
                cht_pkg::REQ_INSERT:
                    e.status = push(b, r.key_hash, r.key_word, r.value_word) ?
                               cht_pkg::ST_OK : cht_pkg::ST_FULL;
                cht_pkg::REQ_ERASE:
                begin
                    hit = lookup(b, r.key_hash, r.key_word, prev);
                    if (hit < NPOOL)
                    begin
                        if (prev < NPOOL) nlink[prev] = nlink[hit];
                        else head[b] = nlink[hit];
                        nlink[hit] = free_top;
                        free_top = hit;
                        if (count > 0) count--;
                        e.value_out = nval[hit];
                        e.status = cht_pkg::ST_OK;
                    end
                end
                cht_pkg::REQ_FIND:
                begin
                    hit = lookup(b, r.key_hash, r.key_word, prev);
                    if (hit < NPOOL)
                    begin
                        e.value_out = nval[hit];
                        e.status = cht_pkg::ST_OK;
                    end
                end
                cht_pkg::REQ_EMPLACE:
                begin
                    hit = lookup(b, r.key_hash, r.key_word, prev);
                    if (hit < NPOOL)
                    begin
                        e.value_out = nval[hit];
                        e.status = cht_pkg::ST_OK;
                    end
                    else if (push(b, r.key_hash, r.key_word, '0))
                    begin
                        e.created = 1'b1;
                        e.status = cht_pkg::ST_OK;
                    end
                    else
                        e.status = cht_pkg::ST_FULL;
                end
                cht_pkg::REQ_CLEAR:
                begin
                    wipe();
                    e.status = cht_pkg::ST_OK;
                end
                default: ;
            endcase
            e.element_count = count[8:0];
            pending.push_back(e);
        endfunction

        // compare a response beat with the oldest expectation
        function void check_response(cht_pkg::rsp_t a);
            cht_pkg::rsp_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.value_out !== e.value_out)
            begin
                $display("%0t: value_out expected %h actual %h", $time, e.value_out,
                         a.value_out);
                errors++;
            end
            if (a.created !== e.created)
            begin
                $display("%0t: created expected %0d actual %0d", $time, e.created, a.created);
                errors++;
            end
            if (a.element_count !== e.element_count)
            begin
                $display("%0t: element_count expected %0d actual %0d", $time,
                         e.element_count, a.element_count);
                errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    logic  [6:0] cfg_wdata;
    logic  req_valid;
    logic  req_stall;
    cht_pkg::req_t req;
    logic  rsp_valid;
    logic  rsp_stall;
    cht_pkg::rsp_t rsp;

    hash_table_scoreboard table_sb;
    int    hold_off_cycles;
    int    stall_mode;
    int    request_count;

    // key pool so that lookups hit
    logic [31:0] hot_hash[16];
    logic [63:0] hot_key[16];

    chained_hash_table_engine uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: stall pattern plus explicit long hold-off
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            rsp_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            table_sb.check_response(rsp);
    end

    // drive one request beat and wait for its acceptance
    task automatic send_request(logic [2:0] op, logic [31:0] h, logic [63:0] k,
                                logic [31:0] v);
        cht_pkg::req_t r;
        r.req_type = op;
        r.key_hash = h;
        r.key_word = k;
        r.value_word = v;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        table_sb.note_request(r);
        request_count++;
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // wait for every response, then let the block settle
    task automatic drain();
        req_valid <= 1'b0;
        while (table_sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_bucket_count(logic [6:0] n);
        drain();
        cfg_wdata <= n;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        table_sb.bucket_cfg = n;
    endtask

    // random request, mostly on hot keys
    task automatic random_request();
        int sel;
        int pick;
        logic [2:0] op;
        logic [31:0] h;
        logic [63:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 30) op = cht_pkg::REQ_INSERT;
        else if (sel < 50) op = cht_pkg::REQ_ERASE;
        else if (sel < 70) op = cht_pkg::REQ_FIND;
        else if (sel < 92) op = cht_pkg::REQ_EMPLACE;
        else if (sel < 94) op = cht_pkg::REQ_CLEAR;
        else op = 3'($urandom_range(5, 7));
        pick = $urandom_range(0, 15);
        if ($urandom_range(0, 9) < 8)
        begin
            h = hot_hash[pick];
            k = hot_key[pick];
        end
        else
        begin
            h = $urandom();
            k = {$urandom(), $urandom()};
        end
        send_request(op, h, k, $urandom());
    endtask

    // random phase with bursts and gaps
    task automatic random_phase(int n);
        int left;
        int burst;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && left > 0)
            begin
                random_request();
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
    endtask

    // stimulus
    initial
    begin
        table_sb = new();
        table_sb.init();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        hold_off_cycles = 0;
        stall_mode = 0;
        request_count = 0;
        for (int i = 0; i < 16; i++)
        begin
            hot_hash[i] = (i < 8) ? 32'(i * 64) : $urandom();
            hot_key[i] = {$urandom(), $urandom()};
        end
        hot_hash[15] = 32'hFFFF_FFFF;
        hot_key[15] = 64'hFFFF_FFFF_FFFF_FFFF;
        hot_key[14] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every request type and the field extremes
        send_request(cht_pkg::REQ_FIND, 32'h0, 64'h0, 32'h0);
        send_request(cht_pkg::REQ_INSERT, 32'h0, 64'h0, 32'hFFFF_FFFF);
        send_request(cht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_request(cht_pkg::REQ_INSERT, 32'h0, 64'h0, 32'h1234_5678);
        send_request(cht_pkg::REQ_FIND, 32'h0, 64'h0, 32'h0);
        send_request(cht_pkg::REQ_FIND, 32'h10, 64'h0, 32'h0);
        send_request(cht_pkg::REQ_ERASE, 32'h0, 64'h0, 32'h0);
        send_request(cht_pkg::REQ_FIND, 32'h0, 64'h0, 32'h0);
        send_request(cht_pkg::REQ_EMPLACE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     32'hAAAA_5555);
        send_request(cht_pkg::REQ_EMPLACE, 32'h5555_AAAA, 64'hAAAA_5555_AAAA_5555,
                     32'h5555_AAAA);
        send_request(cht_pkg::REQ_ERASE, 32'h1, 64'h1, 32'h0);
        send_request(3'd5, 32'h0, 64'h0, 32'h0);
        send_request(3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(cht_pkg::REQ_CLEAR, 32'h0, 64'h0, 32'h0);
        send_request(cht_pkg::REQ_FIND, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);

        // fill the pool to full, then overflow both ways
        for (int i = 0; i < 258; i++)
            send_request(cht_pkg::REQ_INSERT, 32'(i), {32'($urandom()), 32'(i)}, $urandom());
        send_request(cht_pkg::REQ_EMPLACE, 32'h77, 64'h77, 32'h0);
        send_request(cht_pkg::REQ_FIND, 32'd3, 64'd3, 32'h0);

        // bucket count extremes and out-of-range values while entries stay linked
        write_bucket_count(7'd0);
        send_request(cht_pkg::REQ_FIND, 32'd5, 64'd5, 32'h0);
        send_request(cht_pkg::REQ_CLEAR, 32'h0, 64'h0, 32'h0);
        stall_mode = 1;
        random_phase(150);
        write_bucket_count(7'd1);
        random_phase(150);
        write_bucket_count(7'd127);
        random_phase(150);
        write_bucket_count(7'd64);

        // long receiver hold-off while the sender keeps offering
        hold_off_cycles = 400;
        random_phase(60);
        // sender waits for every response before going on
        drain();
        stall_mode = 2;
        random_phase(60);
        write_bucket_count(7'd65);
        random_phase(100);
        write_bucket_count(7'd7);
        stall_mode = 0;
        random_phase(150);
        write_bucket_count(7'd3);
        stall_mode = 1;
        random_phase(150);
        drain();

        $display("covered %0d requests over bucket counts 0, 1, 3, 7, 16, 64, 65, 127",
                 request_count);
        $display("pool overflow, duplicates, clears and %0d checked responses",
                 table_sb.checked);
        if (table_sb.errors == 0 && table_sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
